// ===== rtl/hntm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hntm_pkg
// Shared widths, codes and types for the nearest-template matcher.
// ----------------------------------------------------------------------------
package hntm_pkg;

   // bank geometry
   localparam int TEMPLATE_COUNT = 16;
   localparam int VECTOR_BITS    = 256;
   localparam int WORD_BITS      = 64;
   localparam int WORD_COUNT     = VECTOR_BITS / WORD_BITS;
   localparam int INDEX_BITS     = (TEMPLATE_COUNT > 1) ? $clog2(TEMPLATE_COUNT) : 1;

   // field widths
   localparam int SLOT_BITS      = 4;
   localparam int DIST_BITS      = 9;
   localparam int POP_BITS       = 7;
   localparam int INDEX_EXT_BITS = (INDEX_BITS > SLOT_BITS) ? INDEX_BITS : SLOT_BITS;

   // running minimum starts above any real distance
   localparam logic [DIST_BITS-1:0] DIST_START = '1;

   // request actions
   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   // register map
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 9;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISTANCE_TOLERANCE = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MINIMUM_MARGIN     = 1'b1;
   localparam logic [CSR_DATA_BITS-1:0]  TOLERANCE_RESET        = 9'd256;
   localparam logic [CSR_DATA_BITS-1:0]  MARGIN_RESET           = 9'd0;

   // control from the sequencer into the distance unit
   typedef struct packed {
      logic                  start;
      logic                  valid;
      logic [INDEX_BITS-1:0] index;
   } hntm_scan_type;

   // running result of the distance unit
   typedef struct packed {
      logic                  pending;
      logic [INDEX_BITS-1:0] best_index;
      logic [DIST_BITS-1:0]  best_distance;
      logic [DIST_BITS-1:0]  second_distance;
   } hntm_track_type;

endpackage

// ===== rtl/hntm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hntm_cell
// One template slot of the ring; loads directly or takes its neighbor's vector.
// ----------------------------------------------------------------------------
module hntm_cell (
   input  logic                             clock,
   input  logic                             load_en,
   input  logic [hntm_pkg::VECTOR_BITS-1:0] load_vector,
   input  logic                             shift_en,
   input  logic [hntm_pkg::VECTOR_BITS-1:0] shift_vector,
   output logic [hntm_pkg::VECTOR_BITS-1:0] template_vector
);

   logic [hntm_pkg::VECTOR_BITS-1:0] template_ff;
   logic [hntm_pkg::VECTOR_BITS-1:0] template_in;

   // load has priority; loads only happen while the ring is at rest
   always_comb begin
      template_in = template_ff;
      if (load_en) begin
         template_in = load_vector;
      end else if (shift_en) begin
         template_in = shift_vector;
      end
   end

   // template storage, undefined until loaded
   always_ff @(posedge clock) begin
      template_ff <= template_in;
   end

   assign template_vector = template_ff;

endmodule

// ===== rtl/hntm_dist.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hntm_dist
// Two-stage Hamming distance unit with running best and second-best tracking.
// ----------------------------------------------------------------------------
module hntm_dist (
   input  logic                             clock,
   input  logic                             reset,
   input  hntm_pkg::hntm_scan_type          scan,
   input  logic [hntm_pkg::VECTOR_BITS-1:0] query_vector,
   input  logic [hntm_pkg::VECTOR_BITS-1:0] template_vector,
   output hntm_pkg::hntm_track_type         track
);

   // balanced adder tree over one 64-bit word
   function automatic logic [hntm_pkg::POP_BITS-1:0] count_ones64(
      input logic [hntm_pkg::WORD_BITS-1:0] x
   );
      logic [1:0] lvl1 [32];
      logic [2:0] lvl2 [16];
      logic [3:0] lvl3 [8];
      logic [4:0] lvl4 [4];
      logic [5:0] lvl5 [2];
      for (int i = 0; i < 32; i++) lvl1[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
      for (int i = 0; i < 16; i++) lvl2[i] = {1'b0, lvl1[2*i]} + {1'b0, lvl1[2*i+1]};
      for (int i = 0; i < 8; i++)  lvl3[i] = {1'b0, lvl2[2*i]} + {1'b0, lvl2[2*i+1]};
      for (int i = 0; i < 4; i++)  lvl4[i] = {1'b0, lvl3[2*i]} + {1'b0, lvl3[2*i+1]};
      for (int i = 0; i < 2; i++)  lvl5[i] = {1'b0, lvl4[2*i]} + {1'b0, lvl4[2*i+1]};
      return {1'b0, lvl5[0]} + {1'b0, lvl5[1]};
   endfunction

   logic [hntm_pkg::VECTOR_BITS-1:0] diff;
   logic [hntm_pkg::POP_BITS-1:0]    pop_in [hntm_pkg::WORD_COUNT];
   logic [hntm_pkg::POP_BITS-1:0]    pop_ff [hntm_pkg::WORD_COUNT];
   logic                             s1_valid_ff;
   logic [hntm_pkg::INDEX_BITS-1:0]  s1_index_ff;
   logic [hntm_pkg::DIST_BITS-1:0]   distance;
   logic [hntm_pkg::DIST_BITS-1:0]   best_ff;
   logic [hntm_pkg::DIST_BITS-1:0]   best_in;
   logic [hntm_pkg::DIST_BITS-1:0]   second_ff;
   logic [hntm_pkg::DIST_BITS-1:0]   second_in;
   logic [hntm_pkg::INDEX_BITS-1:0]  best_at_ff;
   logic [hntm_pkg::INDEX_BITS-1:0]  best_at_in;

   // stage 1: per-word bit counts of the xor
   assign diff = query_vector ^ template_vector;

   always_comb begin
      for (int w = 0; w < hntm_pkg::WORD_COUNT; w++) begin
         pop_in[w] = count_ones64(diff[w*hntm_pkg::WORD_BITS +: hntm_pkg::WORD_BITS]);
      end
   end

   always_ff @(posedge clock) begin
      for (int w = 0; w < hntm_pkg::WORD_COUNT; w++) begin
         pop_ff[w] <= pop_in[w];
      end
      s1_index_ff <= scan.index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= scan.valid;
      end
   end

   // stage 2: total distance and min / second-min update, first index wins ties
   always_comb begin
      distance = '0;
      for (int w = 0; w < hntm_pkg::WORD_COUNT; w++) begin
         distance = distance + hntm_pkg::DIST_BITS'(pop_ff[w]);
      end
   end

   always_comb begin
      best_in    = best_ff;
      second_in  = second_ff;
      best_at_in = best_at_ff;
      if (scan.start) begin
         best_in    = hntm_pkg::DIST_START;
         second_in  = hntm_pkg::DIST_START;
         best_at_in = '0;
      end else if (s1_valid_ff) begin
         if (distance < best_ff) begin
            second_in  = best_ff;
            best_in    = distance;
            best_at_in = s1_index_ff;
         end else if (distance < second_ff) begin
            second_in = distance;
         end
      end
   end

   always_ff @(posedge clock) begin
      best_ff    <= best_in;
      second_ff  <= second_in;
      best_at_ff <= best_at_in;
   end

   assign track.pending         = s1_valid_ff;
   assign track.best_index      = best_at_ff;
   assign track.best_distance   = best_ff;
   assign track.second_distance = second_ff;

endmodule

// ===== rtl/hamming_nearest_template_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_nearest_template_match
// Nearest-template classifier over 256-bit vectors by Hamming distance.
// ----------------------------------------------------------------------------
// A load request writes one template into its slot and gives no response.
// A query request keeps the request channel busy from acceptance until its
// result is written to the response register: the templates sit in a ring
// of cells that rotates one step per cycle, and the template at the head of
// the ring feeds a two-stage distance unit, so the bank size sets how long a
// query takes. The response is held in an output register;
// load requests are still taken while a response waits. If the response
// register is still full when a query finishes, the block waits for it to
// drain. Every slot must be loaded before the first query.
// ----------------------------------------------------------------------------
module hamming_nearest_template_match (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic [hntm_pkg::SLOT_BITS-1:0]      req_slot,
   input  logic [hntm_pkg::WORD_BITS-1:0]      req_vector_word0,
   input  logic [hntm_pkg::WORD_BITS-1:0]      req_vector_word1,
   input  logic [hntm_pkg::WORD_BITS-1:0]      req_vector_word2,
   input  logic [hntm_pkg::WORD_BITS-1:0]      req_vector_word3,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [hntm_pkg::SLOT_BITS-1:0]      rsp_best_index,
   output logic [hntm_pkg::DIST_BITS-1:0]      rsp_best_distance,
   output logic [hntm_pkg::DIST_BITS-1:0]      rsp_distance_margin,
   output logic                                rsp_accepted,
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hntm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [hntm_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   localparam logic [hntm_pkg::INDEX_BITS-1:0] LAST_INDEX =
      hntm_pkg::INDEX_BITS'(hntm_pkg::TEMPLATE_COUNT - 1);

   logic [1:0]                          state_ff;
   logic [1:0]                          state_in;
   logic [hntm_pkg::INDEX_BITS-1:0]     count_ff;
   logic [hntm_pkg::INDEX_BITS-1:0]     count_in;
   logic [hntm_pkg::VECTOR_BITS-1:0]    query_ff;
   logic [hntm_pkg::VECTOR_BITS-1:0]    req_vector;
   logic                                req_fire;
   logic                                load_fire;
   logic                                query_fire;
   logic                                scanning;
   logic                                finish_now;
   logic [hntm_pkg::TEMPLATE_COUNT-1:0] load_hit;
   logic [hntm_pkg::VECTOR_BITS-1:0]    ring_vector [hntm_pkg::TEMPLATE_COUNT];
   hntm_pkg::hntm_scan_type             scan;
   hntm_pkg::hntm_track_type            track;
   logic [hntm_pkg::CSR_DATA_BITS-1:0]  tolerance_ff;
   logic [hntm_pkg::CSR_DATA_BITS-1:0]  margin_min_ff;
   logic [hntm_pkg::DIST_BITS-1:0]      margin;
   logic                                accept_flag;
   logic [hntm_pkg::INDEX_EXT_BITS-1:0] best_index_ext;
   logic                                rsp_valid_ff;
   logic [hntm_pkg::SLOT_BITS-1:0]      rsp_index_ff;
   logic [hntm_pkg::DIST_BITS-1:0]      rsp_distance_ff;
   logic [hntm_pkg::DIST_BITS-1:0]      rsp_margin_ff;
   logic                                rsp_accepted_ff;

   // request handshake
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign load_fire  = req_fire && (req_action == hntm_pkg::ACTION_LOAD);
   assign query_fire = req_fire && (req_action == hntm_pkg::ACTION_QUERY);
   assign req_vector = {req_vector_word3, req_vector_word2, req_vector_word1, req_vector_word0};
   assign scanning   = (state_ff == ST_SCAN);
   assign finish_now = (state_ff == ST_FINISH) && !track.pending &&
                       (!rsp_valid_ff || rsp_ready);

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      case (state_ff)
         ST_IDLE: begin
            count_in = '0;
            if (query_fire) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            count_in = count_ff + 1'b1;
            if (count_ff == LAST_INDEX) begin
               count_in = '0;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish_now) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // query vector holds for the whole scan
   always_ff @(posedge clock) begin
      if (query_fire) begin
         query_ff <= req_vector;
      end
   end

   // ring of template cells; cell 0 feeds the distance unit
   genvar k;
   generate
      for (k = 0; k < hntm_pkg::TEMPLATE_COUNT; k++) begin : g_cell
         if (k < (1 << hntm_pkg::SLOT_BITS)) begin : g_hit
            assign load_hit[k] = load_fire && (req_slot == hntm_pkg::SLOT_BITS'(k));
         end else begin : g_nohit
            assign load_hit[k] = 1'b0;
         end

         hntm_cell u_cell (
            .clock           (clock),
            .load_en         (load_hit[k]),
            .load_vector     (req_vector),
            .shift_en        (scanning),
            .shift_vector    (ring_vector[(k + 1) % hntm_pkg::TEMPLATE_COUNT]),
            .template_vector (ring_vector[k])
         );
      end
   endgenerate

   // distance unit
   assign scan.start = query_fire;
   assign scan.valid = scanning;
   assign scan.index = count_ff;

   hntm_dist u_dist (
      .clock           (clock),
      .reset           (reset),
      .scan            (scan),
      .query_vector    (query_ff),
      .template_vector (ring_vector[0]),
      .track           (track)
   );

   // final decision
   assign margin         = track.second_distance - track.best_distance;
   assign accept_flag    = (track.best_distance <= tolerance_ff) && (margin >= margin_min_ff);
   assign best_index_ext = hntm_pkg::INDEX_EXT_BITS'(track.best_index);

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish_now) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_now) begin
         rsp_index_ff    <= best_index_ext[hntm_pkg::SLOT_BITS-1:0];
         rsp_distance_ff <= track.best_distance;
         rsp_margin_ff   <= margin;
         rsp_accepted_ff <= accept_flag;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_best_index      = rsp_index_ff;
   assign rsp_best_distance   = rsp_distance_ff;
   assign rsp_distance_margin = rsp_margin_ff;
   assign rsp_accepted        = rsp_accepted_ff;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff  <= hntm_pkg::TOLERANCE_RESET;
         margin_min_ff <= hntm_pkg::MARGIN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            hntm_pkg::CSR_DISTANCE_TOLERANCE: tolerance_ff  <= csr_data;
            hntm_pkg::CSR_MINIMUM_MARGIN:     margin_min_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

endmodule
